/* sv/flr_pkg.sv */
`timescale 1ns / 1ps
package flr_pkg;

	typedef enum logic [2:0] {
		REQ_BEGIN   = 3'd0,
		REQ_PAYLOAD = 3'd1,
		REQ_TAKE    = 3'd2,
		REQ_READ    = 3'd3,
		REQ_RESYNC  = 3'd4
	} req_e;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVCHK,
		S_HDR,
		S_CONV,
		S_EVICT,
		S_HWR,
		S_BCONV,
		S_TCHK,
		S_TREC,
		S_RCHK,
		S_RREC,
		S_DAT,
		S_DONE
	} state_e;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] record_ms;
		logic [15:0] record_len;
		logic        on_console;
		logic [7:0]  payload_byte;
		logic [63:0] read_offset;
	} in_t;

	typedef struct packed {
		logic        out_valid;
		logic [7:0]  out_byte;
		logic        last_of_record;
		logic        accepted;
		logic [63:0] render_total_out;
		logic [63:0] render_oldest_out;
		logic [13:0] stored_bytes;
		logic [10:0] record_count;
		logic [31:0] drop_count;
		logic [31:0] truncation_count;
		logic [63:0] gap_byte_total;
		logic [31:0] gap_count;
	} out_t;

	typedef struct packed {
		logic       ready;
		logic [3:0] slen;
	} stamp_st_t;

	localparam int unsigned HDR_BYTES   = 6;
	localparam logic [31:0] NO_STAMP    = 32'hFFFF_FFFF;
	localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
	localparam int unsigned DIV10_SHIFT = 35;
	localparam logic [7:0]  CH_LBR      = 8'h5B;
	localparam logic [7:0]  CH_RBR      = 8'h5D;
	localparam logic [7:0]  CH_DOT      = 8'h2E;
	localparam logic [7:0]  CH_SP       = 8'h20;
	localparam logic [7:0]  CH_ZERO     = 8'h30;

endpackage

/* sv/flr_ram.sv */
`timescale 1ns / 1ps
module flr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/flr_stamp.sv */
`timescale 1ns / 1ps
module flr_stamp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [31:0]           ms,
	input  logic [3:0]            idx,
	output flr_pkg::stamp_st_t    st,
	output logic [7:0]            sbyte
);

	logic [31:0] x_q;
	logic [3:0]  dig_q [10];
	logic [3:0]  k_q;
	logic [3:0]  top_q;
	logic        run_q;
	logic        ready_q;
	logic        none_q;

	logic [63:0] prod;
	logic [31:0] quo;
	logic [31:0] rem32;
	logic [3:0]  rem;
	logic [3:0]  d;
	logic [3:0]  w;
	logic [3:0]  k;
	logic [3:0]  j;

	// one decimal digit per cycle, divide by ten via reciprocal
	assign prod  = x_q * flr_pkg::DIV10_MAGIC;
	assign quo   = 32'(prod >> flr_pkg::DIV10_SHIFT);
	assign rem32 = x_q - ((quo << 3) + (quo << 1));
	assign rem   = rem32[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			ready_q <= 1'b0;
			k_q     <= '0;
		end else if (go) begin
			run_q   <= 1'b1;
			ready_q <= 1'b0;
			k_q     <= '0;
		end else if (run_q) begin
			k_q <= k_q + 4'd1;
			if (k_q == 4'd9) begin
				run_q   <= 1'b0;
				ready_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q    <= ms;
			none_q <= (ms == flr_pkg::NO_STAMP);
			top_q  <= 4'd1;
		end else if (run_q) begin
			x_q        <= quo;
			dig_q[k_q] <= rem;
			if (rem != 4'd0) begin
				top_q <= k_q + 4'd1;
			end
		end
	end

	// digits of ms: low three are the fraction, the rest are seconds
	assign d = (top_q > 4'd3) ? top_q - 4'd3 : 4'd1;
	assign w = (d < 4'd5) ? 4'd5 : d;
	assign k = idx - 4'd1;
	assign j = w + 4'd2 - k;

	assign st.ready = ready_q;
	assign st.slen  = none_q ? 4'd0 : w + 4'd7;

	always_comb begin
		sbyte = flr_pkg::CH_SP;
		if (idx == 4'd0) begin
			sbyte = flr_pkg::CH_LBR;
		end else if (idx <= w) begin
			if (k >= w - d && j < 4'd10) begin
				sbyte = flr_pkg::CH_ZERO + 8'(dig_q[j]);
			end
		end else if (idx == w + 4'd1) begin
			sbyte = flr_pkg::CH_DOT;
		end else if (idx == w + 4'd2) begin
			sbyte = flr_pkg::CH_ZERO + 8'(dig_q[2]);
		end else if (idx == w + 4'd3) begin
			sbyte = flr_pkg::CH_ZERO + 8'(dig_q[1]);
		end else if (idx == w + 4'd4) begin
			sbyte = flr_pkg::CH_ZERO + 8'(dig_q[0]);
		end else if (idx == w + 4'd5) begin
			sbyte = flr_pkg::CH_RBR;
		end
	end

endmodule

/* sv/framed_log_ring_with_eviction.sv */
`timescale 1ns / 1ps
// Framed log ring: records (6-byte header + payload) in a byte RAM, read back
// in rendered form "[sssss.mmm] payload".
// Input: a request transfers when start is high and busy is low. Every
// request gives exactly one result: done pulses for one cycle with result
// holding the delivered byte (if any) and the status after the request.
// The receiver cannot stall; results are never held.
// Latency and throughput:
//   payload byte: result the next cycle, a new request may be taken in the
//     cycle that shows the result, so one byte per cycle.
//   begin: the header write and timestamp sizing, plus a header walk and
//     decimal conversion for each oldest record evicted.
//   take / read: 6 RAM reads plus a decimal conversion for each record header
//     walked, plus a RAM read for a payload byte.
// The RAM port and the serial digit converter set the pace of these steps.
// Reset clears all positions and counters; the RAM is not cleared and no
// clearing pass runs, so the block takes requests right after reset.
module framed_log_ring_with_eviction #(
	parameter int RING_BYTES = 8192,
	parameter int MAX_RECORD = 320
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  flr_pkg::in_t   request,
	output logic           done,
	output flr_pkg::out_t  result
);

	localparam int AW = $clog2(RING_BYTES);
	localparam int LW = $clog2(MAX_RECORD + 1);
	localparam int IW = $clog2(MAX_RECORD + 15);
	localparam int HW = $clog2(RING_BYTES / 6 + 2);
	localparam logic [63:0] RING64 = 64'(RING_BYTES);
	localparam logic [AW:0] RINGA  = (AW + 1)'(RING_BYTES);
	localparam logic [15:0] MAXR16 = 16'(MAX_RECORD);
	localparam logic [AW:0] HDRA   = (AW + 1)'(flr_pkg::HDR_BYTES);

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW:0] n);
		logic [AW:0] s;
		s = {1'b0, a} + n;
		if (s >= RINGA) begin
			s = s - RINGA;
		end
		return s[AW-1:0];
	endfunction

	flr_pkg::state_e state_q, state_d;
	flr_pkg::req_e   op_q;
	flr_pkg::in_t    req_q;

	logic [2:0]    hk_q;
	logic [7:0]    hb_q [6];
	logic [AW-1:0] ha_q, wa_q;
	logic [LW-1:0] lt_q, keep_q, olen_q;
	logic [15:0]   rem_q;
	logic          open_q;
	logic [3:0]    oslen_q;
	logic [63:0]   se_q, ss_q, re_q, rs_q, crp_q, csp_q;
	logic [AW-1:0] sea_q, ssa_q, csa_q;
	logic [IW-1:0] cbi_q;
	logic [HW-1:0] held_q;
	logic [31:0]   drop_q, trunc_q, gaps_q;
	logic [63:0]   gapb_q;
	logic [63:0]   wp_q, wr_q, off_q;
	logic [AW-1:0] wra_q;
	logic          ov_q, ol_q, oa_q;
	logic [7:0]    ob_q;

	logic          accept;
	logic [31:0]   hms;
	logic [15:0]   hword;
	logic [LW-1:0] hlen;
	logic          hcons;
	logic [IW-1:0] rlen;
	logic [AW:0]   hstep;
	logic [63:0]   adv64;
	logic [63:0]   rlen64;
	logic [LW-1:0] lt_in;
	logic          drop_c;
	logic [63:0]   offc;
	logic          rpast_c;
	logic          evict_c;
	logic          tskip_c;
	logic          tstamp_c;
	logic          rhit_c;
	logic [IW-1:0] ri;
	logic          rstamp_c;
	logic [15:0]   hdr_word;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;
	logic          st_go;
	logic [31:0]   st_ms;
	logic [3:0]    st_idx;
	flr_pkg::stamp_st_t st;
	logic [7:0]    st_byte;

	flr_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	flr_stamp u_stamp (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (st_go),
		.ms     (st_ms),
		.idx    (st_idx),
		.st     (st),
		.sbyte  (st_byte)
	);

	assign busy   = !(state_q == flr_pkg::S_IDLE || state_q == flr_pkg::S_DONE);
	assign accept = start && !busy;
	assign done   = (state_q == flr_pkg::S_DONE);

	assign hms    = {hb_q[3], hb_q[2], hb_q[1], hb_q[0]};
	assign hword  = {hb_q[5], hb_q[4]};
	assign hlen   = LW'(hword[14:0]);
	assign hcons  = hword[15];
	assign rlen   = IW'(st.slen) + IW'(hlen);
	assign hstep  = HDRA + (AW + 1)'(hlen);
	assign adv64  = 64'(flr_pkg::HDR_BYTES) + 64'(hlen);
	assign rlen64 = 64'(rlen);

	assign lt_in   = (request.record_len > MAXR16) ? LW'(MAXR16) : LW'(request.record_len);
	assign drop_c  = (32'(flr_pkg::HDR_BYTES) + 32'(lt_in)) > 32'(RING_BYTES);
	assign offc    = (request.read_offset < rs_q) ? rs_q : request.read_offset;
	assign rpast_c = (offc >= re_q);
	assign evict_c = ((se_q - ss_q + 64'(flr_pkg::HDR_BYTES) + 64'(lt_q)) > RING64)
	                 && (ss_q < se_q);
	assign tskip_c  = hcons || (cbi_q >= rlen);
	assign tstamp_c = (cbi_q < IW'(st.slen));
	assign rhit_c   = (off_q < wr_q + rlen64);
	assign ri       = IW'(off_q - wr_q);
	assign rstamp_c = (ri < IW'(st.slen));
	assign hdr_word = {req_q.on_console, 15'(lt_q)};
	assign st_idx   = (op_q == flr_pkg::REQ_TAKE) ? cbi_q[3:0] : ri[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = wa_q;
		ram_wdata = request.payload_byte;
		ram_raddr = ha_q;
		st_go     = 1'b0;
		st_ms     = hms;
		case (state_q)
			flr_pkg::S_IDLE, flr_pkg::S_DONE: begin
				state_d = flr_pkg::S_IDLE;
				if (accept) begin
					case (request.req_type)
						flr_pkg::REQ_BEGIN: begin
							state_d = drop_c ? flr_pkg::S_DONE : flr_pkg::S_EVCHK;
						end
						flr_pkg::REQ_TAKE: begin
							state_d = flr_pkg::S_TCHK;
						end
						flr_pkg::REQ_READ: begin
							state_d = rpast_c ? flr_pkg::S_DONE : flr_pkg::S_RCHK;
						end
						default: begin
							state_d = flr_pkg::S_DONE;
						end
					endcase
					if (request.req_type == flr_pkg::REQ_PAYLOAD && rem_q != 16'd0
					    && open_q && keep_q != '0) begin
						ram_we = 1'b1;
					end
				end
			end
			flr_pkg::S_EVCHK: begin
				state_d = evict_c ? flr_pkg::S_HDR : flr_pkg::S_HWR;
			end
			flr_pkg::S_HDR: begin
				if (hk_q == 3'd6) begin
					st_go   = 1'b1;
					state_d = flr_pkg::S_CONV;
				end
			end
			flr_pkg::S_CONV: begin
				if (st.ready) begin
					case (op_q)
						flr_pkg::REQ_BEGIN: state_d = flr_pkg::S_EVICT;
						flr_pkg::REQ_TAKE:  state_d = flr_pkg::S_TREC;
						default:            state_d = flr_pkg::S_RREC;
					endcase
				end
			end
			flr_pkg::S_EVICT: begin
				state_d = flr_pkg::S_EVCHK;
			end
			flr_pkg::S_HWR: begin
				ram_we = 1'b1;
				case (hk_q)
					3'd0:    ram_wdata = req_q.record_ms[7:0];
					3'd1:    ram_wdata = req_q.record_ms[15:8];
					3'd2:    ram_wdata = req_q.record_ms[23:16];
					3'd3:    ram_wdata = req_q.record_ms[31:24];
					3'd4:    ram_wdata = hdr_word[7:0];
					default: ram_wdata = hdr_word[15:8];
				endcase
				if (hk_q == 3'd5) begin
					st_go   = 1'b1;
					st_ms   = req_q.record_ms;
					state_d = flr_pkg::S_BCONV;
				end
			end
			flr_pkg::S_BCONV: begin
				if (st.ready) begin
					state_d = flr_pkg::S_DONE;
				end
			end
			flr_pkg::S_TCHK: begin
				state_d = (csp_q >= se_q) ? flr_pkg::S_DONE : flr_pkg::S_HDR;
			end
			flr_pkg::S_TREC: begin
				ram_raddr = wrap_add(csa_q, HDRA + (AW + 1)'(cbi_q - IW'(st.slen)));
				if (tskip_c) begin
					state_d = flr_pkg::S_TCHK;
				end else begin
					state_d = tstamp_c ? flr_pkg::S_DONE : flr_pkg::S_DAT;
				end
			end
			flr_pkg::S_RCHK: begin
				state_d = (wp_q >= se_q) ? flr_pkg::S_DONE : flr_pkg::S_HDR;
			end
			flr_pkg::S_RREC: begin
				ram_raddr = wrap_add(wra_q, HDRA + (AW + 1)'(ri - IW'(st.slen)));
				if (rhit_c) begin
					state_d = rstamp_c ? flr_pkg::S_DONE : flr_pkg::S_DAT;
				end else begin
					state_d = flr_pkg::S_RCHK;
				end
			end
			flr_pkg::S_DAT: begin
				state_d = flr_pkg::S_DONE;
			end
			default: begin
				state_d = flr_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= flr_pkg::REQ_BEGIN;
			hk_q    <= '0;
			ha_q    <= '0;
			wa_q    <= '0;
			lt_q    <= '0;
			keep_q  <= '0;
			olen_q  <= '0;
			rem_q   <= '0;
			open_q  <= 1'b0;
			oslen_q <= '0;
			se_q    <= '0;
			ss_q    <= '0;
			re_q    <= '0;
			rs_q    <= '0;
			crp_q   <= '0;
			csp_q   <= '0;
			sea_q   <= '0;
			ssa_q   <= '0;
			csa_q   <= '0;
			cbi_q   <= '0;
			held_q  <= '0;
			drop_q  <= '0;
			trunc_q <= '0;
			gaps_q  <= '0;
			gapb_q  <= '0;
			wp_q    <= '0;
			wr_q    <= '0;
			wra_q   <= '0;
			off_q   <= '0;
			ov_q    <= 1'b0;
			ol_q    <= 1'b0;
			oa_q    <= 1'b0;
			ob_q    <= '0;
		end else begin
			case (state_q)
				flr_pkg::S_IDLE, flr_pkg::S_DONE: begin
					if (accept) begin
						op_q <= flr_pkg::req_e'(request.req_type);
						ov_q <= 1'b0;
						ol_q <= 1'b0;
						oa_q <= 1'b0;
						ob_q <= '0;
						case (request.req_type)
							flr_pkg::REQ_BEGIN: begin
								open_q <= 1'b0;
								lt_q   <= lt_in;
								rem_q  <= request.record_len;
								if (request.record_len > MAXR16) begin
									trunc_q <= trunc_q + 32'd1;
								end
								if (drop_c) begin
									drop_q <= drop_q + 32'd1;
									keep_q <= '0;
								end
							end
							flr_pkg::REQ_PAYLOAD: begin
								if (rem_q != 16'd0) begin
									if (open_q && keep_q != '0) begin
										wa_q   <= wrap_add(wa_q, (AW + 1)'(1));
										keep_q <= keep_q - LW'(1);
									end
									rem_q <= rem_q - 16'd1;
									if (rem_q == 16'd1 && open_q) begin
										se_q   <= se_q + 64'(flr_pkg::HDR_BYTES) + 64'(olen_q);
										sea_q  <= wrap_add(sea_q, HDRA + (AW + 1)'(olen_q));
										re_q   <= re_q + 64'(oslen_q) + 64'(olen_q);
										held_q <= held_q + HW'(1);
										open_q <= 1'b0;
									end
								end
							end
							flr_pkg::REQ_TAKE: begin
								// consumer overrun by eviction: count the gap, restart at oldest
								if (csp_q < ss_q) begin
									if (rs_q > crp_q) begin
										gapb_q <= gapb_q + (rs_q - crp_q);
									end
									gaps_q <= gaps_q + 32'd1;
									csp_q  <= ss_q;
									csa_q  <= ssa_q;
									crp_q  <= rs_q;
									cbi_q  <= '0;
								end
							end
							flr_pkg::REQ_READ: begin
								off_q <= offc;
								wp_q  <= ss_q;
								wra_q <= ssa_q;
								wr_q  <= rs_q;
							end
							flr_pkg::REQ_RESYNC: begin
								crp_q <= re_q;
								csp_q <= se_q;
								csa_q <= sea_q;
								cbi_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				flr_pkg::S_EVCHK: begin
					hk_q <= '0;
					if (evict_c) begin
						ha_q <= ssa_q;
					end else begin
						wa_q <= sea_q;
					end
				end
				flr_pkg::S_HDR: begin
					if (hk_q != 3'd6) begin
						ha_q <= wrap_add(ha_q, (AW + 1)'(1));
					end
					if (hk_q != 3'd0) begin
						hb_q[hk_q - 3'd1] <= ram_rdata;
					end
					hk_q <= hk_q + 3'd1;
				end
				flr_pkg::S_EVICT: begin
					ss_q  <= ss_q + adv64;
					ssa_q <= wrap_add(ssa_q, hstep);
					rs_q  <= rs_q + 64'(st.slen) + 64'(hlen);
					if (held_q != '0) begin
						held_q <= held_q - HW'(1);
					end
				end
				flr_pkg::S_HWR: begin
					wa_q <= wrap_add(wa_q, (AW + 1)'(1));
					hk_q <= hk_q + 3'd1;
				end
				flr_pkg::S_BCONV: begin
					if (st.ready) begin
						open_q  <= 1'b1;
						olen_q  <= lt_q;
						keep_q  <= lt_q;
						oslen_q <= st.slen;
						oa_q    <= 1'b1;
						if (rem_q == 16'd0) begin
							se_q   <= se_q + 64'(flr_pkg::HDR_BYTES) + 64'(lt_q);
							sea_q  <= wrap_add(sea_q, HDRA + (AW + 1)'(lt_q));
							re_q   <= re_q + 64'(st.slen) + 64'(lt_q);
							held_q <= held_q + HW'(1);
							open_q <= 1'b0;
						end
					end
				end
				flr_pkg::S_TCHK: begin
					ha_q <= csa_q;
					hk_q <= '0;
				end
				flr_pkg::S_TREC: begin
					if (tskip_c) begin
						if (cbi_q < rlen) begin
							crp_q <= crp_q + 64'(rlen - cbi_q);
						end
						csp_q <= csp_q + adv64;
						csa_q <= wrap_add(csa_q, hstep);
						cbi_q <= '0;
					end else begin
						ov_q  <= 1'b1;
						ob_q  <= st_byte;
						crp_q <= crp_q + 64'd1;
						ol_q  <= (IW'(cbi_q + IW'(1)) == rlen);
						if (IW'(cbi_q + IW'(1)) == rlen) begin
							csp_q <= csp_q + adv64;
							csa_q <= wrap_add(csa_q, hstep);
							cbi_q <= '0;
						end else begin
							cbi_q <= cbi_q + IW'(1);
						end
					end
				end
				flr_pkg::S_RCHK: begin
					ha_q <= wra_q;
					hk_q <= '0;
				end
				flr_pkg::S_RREC: begin
					if (rhit_c) begin
						ov_q <= 1'b1;
						ob_q <= st_byte;
						ol_q <= (IW'(ri + IW'(1)) == rlen);
					end else begin
						wp_q  <= wp_q + adv64;
						wra_q <= wrap_add(wra_q, hstep);
						wr_q  <= wr_q + rlen64;
					end
				end
				flr_pkg::S_DAT: begin
					ob_q <= ram_rdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
	end

	assign result.out_valid         = ov_q;
	assign result.out_byte          = ob_q;
	assign result.last_of_record    = ol_q;
	assign result.accepted          = oa_q;
	assign result.render_total_out  = re_q;
	assign result.render_oldest_out = rs_q;
	assign result.stored_bytes      = 14'(se_q - ss_q);
	assign result.record_count      = 11'(held_q);
	assign result.drop_count        = drop_q;
	assign result.truncation_count  = trunc_q;
	assign result.gap_byte_total    = gapb_q;
	assign result.gap_count         = gaps_q;

`ifndef SYNTHESIS
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		(se_q - ss_q) <= RING64)
		else $error("stored span exceeds ring size");

	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (16'(keep_q) <= rem_q))
		else $error("open record keeps more bytes than remain");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start && !busy)))
		else $error("result strobe without a request in flight");

	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == flr_pkg::S_HWR || (accept && open_q)))
		else $error("ring write outside header or payload transfer");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import flr_pkg::*;

	localparam int unsigned RING = 8192;
	localparam int unsigned MAXREC = 320;
	localparam logic [15:0] CON_BIT = 16'h8000;
	localparam logic [15:0] LEN_MASK = 16'h7FFF;
	localparam logic [2:0] REQ_UNK_LO = 3'd5;
	localparam logic [2:0] REQ_UNK_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	in_t request = '0;
	out_t result;

	framed_log_ring_with_eviction u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .done(done), .result(result)
	);

	always #4 clk = ~clk;

	// shadow of the log ring
	logic [7:0] shadow_ring [RING];
	longint unsigned st_end, st_start, rd_end, rd_start, cur_rpos, cur_spos;
	int unsigned cur_idx, app_rem, app_keep, held, open_ms, open_len;
	longint unsigned n_drop, n_trunc, gap_bytes, n_gap;
	bit open_v;

	out_t pending_results [$];
	int unsigned n_err = 0;
	int unsigned n_items = 0;
	int unsigned idle_pct = 26;

	typedef struct {
		in_t req;
		bit chk;
		logic v;
		logic [7:0] b;
		logic a;
	} row_t;
	row_t stim_rows [$];

	function automatic logic [7:0] ring_at(longint unsigned pos);
		return shadow_ring[pos % RING];
	endfunction

	function automatic void hdr_at(longint unsigned pos, output logic [31:0] ms,
			output logic [15:0] w);
		ms = {ring_at(pos + 3), ring_at(pos + 2), ring_at(pos + 1), ring_at(pos)};
		w = {ring_at(pos + 5), ring_at(pos + 4)};
	endfunction

	function automatic int unsigned stamp_make(logic [31:0] ms, output logic [7:0] t [16]);
		logic [7:0] dig [10];
		int unsigned n, d, sec, frac;
		n = 0;
		d = 0;
		for (int k = 0; k < 16; k++) t[k] = 8'h00;
		if (ms == NO_STAMP) return 0;
		sec = ms / 1000;
		frac = ms % 1000;
		t[n] = CH_LBR; n++;
		do begin
			dig[d] = CH_ZERO + 8'(sec % 10); d++; sec = sec / 10;
		end while (sec != 0 && d < 10);
		for (int unsigned p = d; p < 5; p++) begin
			t[n] = CH_SP; n++;
		end
		while (d > 0) begin
			d--; t[n] = dig[d]; n++;
		end
		t[n] = CH_DOT; n++;
		t[n] = CH_ZERO + 8'((frac / 100) % 10); n++;
		t[n] = CH_ZERO + 8'((frac / 10) % 10); n++;
		t[n] = CH_ZERO + 8'(frac % 10); n++;
		t[n] = CH_RBR; n++;
		t[n] = CH_SP; n++;
		return n;
	endfunction

	function automatic int unsigned stamp_len(logic [31:0] ms);
		logic [7:0] t [16];
		return stamp_make(ms, t);
	endfunction

	function automatic logic [7:0] render_at(longint unsigned spos, logic [31:0] ms,
			int unsigned i);
		logic [7:0] t [16];
		int unsigned tl;
		tl = stamp_make(ms, t);
		if (i < tl) return t[i];
		return ring_at(spos + HDR_BYTES + (i - tl));
	endfunction

	function automatic void shadow_reset();
		st_end = 0; st_start = 0; rd_end = 0; rd_start = 0;
		cur_rpos = 0; cur_spos = 0; cur_idx = 0;
		app_rem = 0; app_keep = 0; held = 0;
		n_drop = 0; n_trunc = 0; gap_bytes = 0; n_gap = 0;
		open_v = 0; open_ms = 0; open_len = 0;
	endfunction

	function automatic void commit_record();
		st_end += HDR_BYTES + open_len;
		rd_end += stamp_len(open_ms) + open_len;
		held++;
		open_v = 0;
	endfunction

	// applies one transfer to the shadow state and returns the status it yields
	function automatic out_t log_ring_step(in_t r);
		out_t o;
		logic [31:0] ms;
		logic [15:0] w;
		int unsigned len, rlen;
		longint unsigned p, off, spos, rpos;
		bit found;
		o = '0;
		case (r.req_type)
			REQ_BEGIN: begin
				len = r.record_len;
				p = st_end;
				open_v = 0;
				if (len > MAXREC) begin
					len = MAXREC;
					n_trunc++;
				end
				app_rem = r.record_len;
				if (HDR_BYTES + len > RING) begin
					n_drop++;
					app_keep = 0;
				end else begin
					while ((st_end + HDR_BYTES + len) - st_start > RING && st_start < st_end) begin
						hdr_at(st_start, ms, w);
						st_start += HDR_BYTES + (w & LEN_MASK);
						rd_start += stamp_len(ms) + (w & LEN_MASK);
						if (held > 0) held--;
					end
					w = 16'(len) & LEN_MASK | (r.on_console ? CON_BIT : 16'h0);
					shadow_ring[p % RING] = r.record_ms[7:0];
					shadow_ring[(p + 1) % RING] = r.record_ms[15:8];
					shadow_ring[(p + 2) % RING] = r.record_ms[23:16];
					shadow_ring[(p + 3) % RING] = r.record_ms[31:24];
					shadow_ring[(p + 4) % RING] = w[7:0];
					shadow_ring[(p + 5) % RING] = w[15:8];
					open_v = 1;
					open_ms = r.record_ms;
					open_len = len;
					app_keep = len;
					o.accepted = 1'b1;
					if (app_rem == 0) commit_record();
				end
			end
			REQ_PAYLOAD: begin
				if (app_rem != 0) begin
					if (open_v && app_keep > 0) begin
						shadow_ring[(st_end + HDR_BYTES + (open_len - app_keep)) % RING] =
							r.payload_byte;
						app_keep--;
					end
					app_rem--;
					if (app_rem == 0 && open_v) commit_record();
				end
			end
			REQ_TAKE: begin
				if (cur_spos < st_start) begin
					if (rd_start > cur_rpos) gap_bytes += rd_start - cur_rpos;
					n_gap++;
					cur_spos = st_start;
					cur_rpos = rd_start;
					cur_idx = 0;
				end
				found = 0;
				while (!found && cur_spos < st_end) begin
					hdr_at(cur_spos, ms, w);
					len = w & LEN_MASK;
					rlen = stamp_len(ms) + len;
					if ((w & CON_BIT) != 0 || cur_idx >= rlen) begin
						if (cur_idx < rlen) cur_rpos += rlen - cur_idx;
						cur_spos += HDR_BYTES + len;
						cur_idx = 0;
					end else begin
						o.out_valid = 1'b1;
						o.out_byte = render_at(cur_spos, ms, cur_idx);
						cur_idx++;
						cur_rpos++;
						o.last_of_record = (cur_idx == rlen);
						if (o.last_of_record) begin
							cur_spos += HDR_BYTES + len;
							cur_idx = 0;
						end
						found = 1;
					end
				end
			end
			REQ_READ: begin
				off = r.read_offset;
				spos = st_start;
				rpos = rd_start;
				if (off < rd_start) off = rd_start;
				found = (off >= rd_end);
				while (!found && spos < st_end) begin
					hdr_at(spos, ms, w);
					len = w & LEN_MASK;
					rlen = stamp_len(ms) + len;
					if (off < rpos + rlen) begin
						o.out_valid = 1'b1;
						o.out_byte = render_at(spos, ms, 32'(off - rpos));
						o.last_of_record = (off - rpos + 1 == rlen);
						found = 1;
					end
					spos += HDR_BYTES + len;
					rpos += rlen;
				end
			end
			REQ_RESYNC: begin
				cur_rpos = rd_end;
				cur_spos = st_end;
				cur_idx = 0;
			end
			default: ;
		endcase
		o.render_total_out = rd_end;
		o.render_oldest_out = rd_start;
		o.stored_bytes = 14'(st_end - st_start);
		o.record_count = 11'(held);
		o.drop_count = 32'(n_drop);
		o.truncation_count = 32'(n_trunc);
		o.gap_byte_total = gap_bytes;
		o.gap_count = 32'(n_gap);
		return o;
	endfunction

	function automatic in_t noise_item();
		in_t r;
		r.req_type = 3'($urandom);
		r.record_ms = $urandom;
		r.record_len = 16'($urandom);
		r.on_console = 1'($urandom);
		r.payload_byte = 8'($urandom);
		r.read_offset = {$urandom, $urandom};
		return r;
	endfunction

	function automatic in_t mk(logic [2:0] kind, logic [31:0] ms, logic [15:0] len,
			logic cons, logic [7:0] pb, logic [63:0] off);
		in_t r;
		r.req_type = kind;
		r.record_ms = ms;
		r.record_len = len;
		r.on_console = cons;
		r.payload_byte = pb;
		r.read_offset = off;
		return r;
	endfunction

	function automatic void add_row(in_t r, bit chk = 0, logic v = 0, logic [7:0] b = 0,
			logic a = 0);
		row_t x;
		x.req = r; x.chk = chk; x.v = v; x.b = b; x.a = a;
		stim_rows.push_back(x);
	endfunction

	// drives one transfer; inputs change only at falling edges
	task automatic send(in_t r, bit chk = 0, logic v = 0, logic [7:0] b = 0, logic a = 0);
		out_t o;
		@(negedge clk);
		if ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		start = 1'b1;
		request = r;
		while (busy) @(negedge clk);
		o = log_ring_step(r);
		if (chk && (o.out_valid !== v || o.out_byte !== b || o.accepted !== a)) begin
			n_err++;
			if (n_err <= 10)
				$display("directed row mismatch: req %0d exp v=%0b b=%02h a=%0b got %p",
					r.req_type, v, b, a, o);
		end
		pending_results.push_back(o);
		n_items++;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic drain();
		start = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_ms();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return NO_STAMP;
			2: return $urandom_range(0, 99999);
			3: return 32'hFFFF_FFFE;
			4: return 32'd0;
			default: return $urandom_range(0, 9999999);
		endcase
	endfunction

	always @(posedge clk) begin
		if (done) begin
			if (pending_results.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected transfer: %p", result);
			end else begin
				out_t e;
				e = pending_results.pop_front();
				if (result.out_valid !== e.out_valid || result.out_byte !== e.out_byte ||
						result.last_of_record !== e.last_of_record ||
						result.accepted !== e.accepted ||
						result.render_total_out !== e.render_total_out ||
						result.render_oldest_out !== e.render_oldest_out ||
						result.stored_bytes !== e.stored_bytes ||
						result.record_count !== e.record_count ||
						result.drop_count !== e.drop_count ||
						result.truncation_count !== e.truncation_count ||
						result.gap_byte_total !== e.gap_byte_total ||
						result.gap_count !== e.gap_count) begin
					n_err++;
					if (n_err <= 10) $display("mismatch\n  exp %p\n  got %p", e, result);
				end
			end
		end
	end

	initial begin
		#200ms;
		$display("[framed_log_ring_with_eviction] ERROR");
		$finish;
	end

	initial begin
		in_t r;
		int unsigned len, cut, waited;
		shadow_reset();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		add_row(mk(REQ_TAKE, 0, 0, 0, 0, 0), 1, 0, 0, 0);
		add_row(mk(REQ_READ, 0, 0, 0, 0, 64'd0), 1, 0, 0, 0);
		add_row(mk(REQ_READ, 0, 0, 0, 0, '1), 1, 0, 0, 0);
		add_row(mk(REQ_RESYNC, 0, 0, 0, 0, 0));
		add_row(mk(REQ_BEGIN, 32'd0, 16'd0, 0, 0, 0), 1, 0, 0, 1);
		add_row(mk(REQ_READ, 0, 0, 0, 0, 64'd0), 1, 1, CH_LBR, 0);
		add_row(mk(REQ_TAKE, 0, 0, 0, 0, 0), 1, 1, CH_LBR, 0);
		add_row(mk(REQ_BEGIN, NO_STAMP, 16'd2, 0, 0, 0), 1, 0, 0, 1);
		add_row(mk(REQ_PAYLOAD, 0, 0, 0, 8'h00, 0));
		add_row(mk(REQ_PAYLOAD, 0, 0, 0, 8'hFF, 0));
		// no record open: ignored
		add_row(mk(REQ_PAYLOAD, 0, 0, 0, 8'hA5, 0));
		// truncated, then abandoned by the next begin
		add_row(mk(REQ_BEGIN, 32'hFFFF_FFFE, 16'hFFFF, 1, 0, 0), 1, 0, 0, 1);
		add_row(mk(REQ_PAYLOAD, 0, 0, 0, 8'h5A, 0));
		add_row(mk(REQ_BEGIN, 32'd12345, 16'd1, 1, 0, 0), 1, 0, 0, 1);
		add_row(mk(REQ_PAYLOAD, 0, 0, 0, 8'h41, 0));
		add_row(mk(REQ_READ, 0, 0, 0, 0, 64'd12), 1, 1, 8'h00, 0);
		add_row(mk(REQ_READ, 0, 0, 0, 0, 64'd13), 1, 1, 8'hFF, 0);
		add_row(mk(REQ_TAKE, 0, 0, 0, 0, 0));
		add_row(mk(REQ_TAKE, 0, 0, 0, 0, 0));
		add_row(mk(REQ_TAKE, 0, 0, 0, 0, 0));
		add_row(mk(REQ_UNK_LO, '1, '1, 1, '1, '1), 1, 0, 0, 0);
		add_row(mk(REQ_UNK_HI, 0, 0, 0, 0, 0), 1, 0, 0, 0);
		add_row(mk(REQ_RESYNC, 0, 0, 0, 0, 0), 1, 0, 0, 0);
		add_row(mk(REQ_TAKE, 0, 0, 0, 0, 0), 1, 0, 0, 0);
		foreach (stim_rows[i])
			send(stim_rows[i].req, stim_rows[i].chk, stim_rows[i].v, stim_rows[i].b,
				stim_rows[i].a);

		// run until the ring has wrapped a few times so eviction and gaps occur
		while (!((n_items >= 950 && st_start >= 3 * RING) || n_items >= 60000)) begin
			case ((n_items / 1500) % 3)
				0: idle_pct = 26;
				1: idle_pct = 50;
				default: idle_pct = 0;
			endcase
			if (n_items % 1500 < 3) drain();
			case ($urandom_range(0, 99)) inside
				[0:54]: begin
					r = noise_item();
					r.req_type = REQ_BEGIN;
					r.record_ms = pick_ms();
					r.on_console = ($urandom_range(0, 99) < 30);
					case ($urandom_range(0, 19))
						0, 1, 2, 3: len = $urandom_range(0, 8);
						4: len = $urandom_range(MAXREC + 1, MAXREC + 20);
						default: len = $urandom_range(60, MAXREC);
					endcase
					r.record_len = 16'(len);
					send(r);
					cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
					for (int unsigned k = 0; k < cut; k++) begin
						r = noise_item();
						r.req_type = REQ_PAYLOAD;
						send(r);
					end
					repeat ($urandom_range(0, 3)) begin
						r = noise_item();
						r.req_type = REQ_TAKE;
						send(r);
					end
				end
				[55:74]: begin
					repeat ($urandom_range(1, 20)) begin
						r = noise_item();
						r.req_type = REQ_TAKE;
						send(r);
					end
				end
				[75:84]: begin
					r = noise_item();
					r.req_type = REQ_READ;
					case ($urandom_range(0, 2))
						0: ;
						1: r.read_offset = rd_start - $urandom_range(0, 50);
						default: r.read_offset = rd_start + $urandom_range(0,
							32'(rd_end - rd_start) + 5);
					endcase
					send(r);
				end
				[85:87]: begin
					r = noise_item();
					r.req_type = REQ_RESYNC;
					send(r);
				end
				[88:91]: begin
					r = noise_item();
					r.req_type = REQ_PAYLOAD;
					send(r);
				end
				[92:94]: begin
					r = noise_item();
					r.req_type = 3'($urandom_range(REQ_UNK_LO, REQ_UNK_HI));
					send(r);
				end
				default: begin
					// random length, left open and abandoned by a later begin
					r = noise_item();
					r.req_type = REQ_BEGIN;
					send(r);
				end
			endcase
		end
		start = 1'b0;

		waited = 0;
		while (pending_results.size() != 0 && waited < 200000) begin
			@(negedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
		if (n_err == 0 && pending_results.size() == 0) begin
			$display("[framed_log_ring_with_eviction] OK");
		end else begin
			$display("[framed_log_ring_with_eviction] ERROR");
		end
		$finish;
	end

endmodule
